@@ hw/rtl/bia_pkg.sv @@
// Shared types and codes for the bitmap index allocator.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package bia_pkg;

	localparam int unsigned CFG_IDX_W = 8;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 8'd1;

	// request operations
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_TAS   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	// response status
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_ALREADY    = 3'd2;
	localparam logic [2:0] ST_BAD_RANGE  = 3'd3;
	localparam logic [2:0] ST_BAD_CONFIG = 3'd4;

	// lowest offset of a word sits at its most significant bit
	localparam logic [31:0] WORD_MSB = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] index;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] result_index;
		logic        is_set;
	} out_beat_t;

	// what the word unit reports about the word under test
	typedef struct packed {
		logic       found;    // a free bit exists inside the valid mask
		logic [4:0] pos;      // first free bit, counted from the MSB
		logic       bit_val;  // value of the selected bit
	} word_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/bia_word_unit.sv @@
// Shared word unit: first-free search from the MSB, bit test and bit update.
// Depends on bia_pkg.
`default_nettype none

module bia_word_unit (
	input  wire logic [31:0]        word,
	input  wire logic [31:0]        valid_mask,
	input  wire logic [4:0]         bit_sel,
	output bia_pkg::word_res_t      res,
	output logic [31:0]             word_alloc,
	output logic [31:0]             word_set,
	output logic [31:0]             word_clr
);

	logic [31:0] free_bits;
	logic [31:0] sel_mask;
	logic        found;
	logic [4:0]  pos;

	assign free_bits = ~word & valid_mask;
	assign sel_mask  = bia_pkg::WORD_MSB >> bit_sel;

	// priority encoder: bit 31 is offset 0, so scan upward and let the last hit win
	always_comb begin
		found = 1'b0;
		pos   = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (free_bits[i]) begin
				found = 1'b1;
				pos   = 5'(31 - i);
			end
		end
	end

	assign res.found   = found;
	assign res.pos     = pos;
	assign res.bit_val = |(word & sel_mask);

	assign word_alloc = word | (bia_pkg::WORD_MSB >> pos);
	assign word_set   = word | sel_mask;
	assign word_clr   = word & ~sel_mask;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_index_allocator.sv @@
// Each request goes from check to test or allocate, then to response; a new input beat is taken only
// after the result beat is loaded. A bad range, a bad config or an allocate with the word hint already
// past the range goes from check straight to response. Allocate steps over each fully used word from
// the lowest-possibly-free word hint, one memory word read per cycle. A stalled result beat holds the
// next request. Reset, and every write of range_low or range_high, start a clearing pass over all
// (MAP_BITS+31)/32 map words; in_stall stays high until it ends. Config writes taken every cycle.
`default_nettype none

module bitmap_index_allocator #(
	parameter int unsigned MAP_BITS = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire bia_pkg::in_beat_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output bia_pkg::out_beat_t                   out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bia_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	localparam int unsigned WORD_COUNT = (MAP_BITS + 31) / 32;
	localparam int unsigned WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int unsigned OW = $clog2(MAP_BITS);
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_TEST  = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]           state_q, state_d;
	logic [31:0]          lo_q, hi_q;
	logic                 cfg_ok_q;
	logic [OW-1:0]        span_q;
	logic [WAW-1:0]       clr_ptr_q, clr_ptr_d;
	logic [WAW:0]         hint_q, hint_d;
	logic [1:0]           op_q, op_d;
	logic [31:0]          idx_q, idx_d;
	logic [WAW-1:0]       word_q, word_d;
	logic [4:0]           bit_q, bit_d;
	bia_pkg::out_beat_t   res_q, res_d;
	logic                 out_valid_q;
	bia_pkg::out_beat_t   out_q;

	logic [31:0]          mem_q [WORD_COUNT];
	logic [31:0]          rd_q;
	logic [WAW-1:0]       rd_addr;
	logic                 we;
	logic [WAW-1:0]       wa;
	logic [31:0]          wd;

	logic                 cfg_we;
	logic                 in_acc;
	logic                 out_acc;
	logic                 load_out;
	logic [31:0]          span_full;
	logic [32:0]          diff;
	logic                 out_of_range;
	logic [31:0]          span_ext;
	logic [WAW-1:0]       last_w;
	logic [31:0]          valid_mask;
	logic [31:0]          alloc_off;

	bia_pkg::word_res_t   wres;
	logic [31:0]          word_alloc, word_set, word_clr;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready &&
		(cfg_index == bia_pkg::REG_RANGE_LOW || cfg_index == bia_pkg::REG_RANGE_HIGH);
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_acc   = out_valid_q && !out_stall;

	assign span_full = hi_q - lo_q;

	// one wide subtract: borrow means below range_low
	assign diff         = {1'b0, idx_q} - {1'b0, lo_q};
	assign out_of_range = diff[32] || (diff[31:0] > 32'(span_q));

	assign span_ext   = 32'(span_q);
	assign last_w     = span_ext[5 +: WAW];
	assign valid_mask = (hint_q[WAW-1:0] == last_w) ?
		~(32'h7FFF_FFFF >> span_q[4:0]) : 32'hFFFF_FFFF;
	assign alloc_off  = (32'(hint_q[WAW-1:0]) << 5) | 32'(wres.pos);

	bia_word_unit u_word (
		.word       (rd_q),
		.valid_mask (valid_mask),
		.bit_sel    (bit_q),
		.res        (wres),
		.word_alloc (word_alloc),
		.word_set   (word_set),
		.word_clr   (word_clr)
	);

	always_comb begin
		state_d   = state_q;
		clr_ptr_d = clr_ptr_q;
		hint_d    = hint_q;
		op_d      = op_q;
		idx_d     = idx_q;
		word_d    = word_q;
		bit_d     = bit_q;
		res_d     = res_q;
		rd_addr   = hint_q[WAW-1:0];
		we        = 1'b0;
		wa        = word_q;
		wd        = word_set;
		load_out  = 1'b0;

		unique case (state_q)
			S_CLR: begin
				we        = 1'b1;
				wa        = clr_ptr_q;
				wd        = '0;
				clr_ptr_d = clr_ptr_q + 1'b1;
				if (clr_ptr_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					op_d    = in_data.opcode;
					idx_d   = in_data.index;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				res_d = '{status: bia_pkg::ST_OK, result_index: 32'd0, is_set: 1'b0};
				word_d = diff[5 +: WAW];
				bit_d  = diff[4:0];
				if (!cfg_ok_q) begin
					res_d.status = bia_pkg::ST_BAD_CONFIG;
					state_d      = S_RESP;
				end else if (op_q == bia_pkg::OP_ALLOC) begin
					if (hint_q > {1'b0, last_w}) begin
						res_d.status = bia_pkg::ST_FULL;
						state_d      = S_RESP;
					end else begin
						state_d = S_ALLOC;
					end
				end else if (out_of_range) begin
					res_d.status = bia_pkg::ST_BAD_RANGE;
					state_d      = S_RESP;
				end else begin
					rd_addr = diff[5 +: WAW];
					state_d = S_TEST;
				end
			end
			S_ALLOC: begin
				// rd_q holds the word at hint_q; fetch the next one in case this is full
				rd_addr = hint_q[WAW-1:0] + 1'b1;
				if (wres.found) begin
					we                 = 1'b1;
					wa                 = hint_q[WAW-1:0];
					wd                 = word_alloc;
					res_d.result_index = lo_q + alloc_off;
					state_d            = S_RESP;
				end else begin
					hint_d = hint_q + 1'b1;
					if (hint_q[WAW-1:0] == last_w) begin
						res_d.status = bia_pkg::ST_FULL;
						state_d      = S_RESP;
					end
				end
			end
			S_TEST: begin
				case (op_q)
					bia_pkg::OP_TAS: begin
						if (wres.bit_val) begin
							res_d.status = bia_pkg::ST_ALREADY;
						end else begin
							we = 1'b1;
							wd = word_set;
						end
					end
					bia_pkg::OP_CLEAR: begin
						we = 1'b1;
						wd = word_clr;
						if ({1'b0, word_q} < hint_q) begin
							hint_d = {1'b0, word_q};
						end
					end
					default: begin
						res_d.is_set = wres.bit_val;
					end
				endcase
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLR;
			end
		endcase

		// a range write wipes the map
		if (cfg_we) begin
			state_d   = S_CLR;
			clr_ptr_d = '0;
			hint_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_ptr_q   <= '0;
			hint_q      <= '0;
			lo_q        <= 32'd0;
			hi_q        <= 32'd1023;
			cfg_ok_q    <= 1'b0;
			span_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_ptr_q <= clr_ptr_d;
			hint_q    <= hint_d;
			// settles during the clearing pass that follows every range write
			cfg_ok_q  <= (hi_q > lo_q) && (span_full < 32'(MAP_BITS));
			span_q    <= span_full[OW-1:0];
			if (cfg_valid && cfg_ready && cfg_index == bia_pkg::REG_RANGE_LOW) begin
				lo_q <= cfg_data;
			end
			if (cfg_valid && cfg_ready && cfg_index == bia_pkg::REG_RANGE_HIGH) begin
				hi_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		idx_q  <= idx_d;
		word_q <= word_d;
		bit_q  <= bit_d;
		res_q  <= res_d;
		if (load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/bia_chk.sv @@
// Port-level checker for the bitmap index allocator, bound to the top level.
// Depends on bia_pkg and bitmap_index_allocator.
`default_nettype none

module bia_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire bia_pkg::out_beat_t              out_data,
	input wire logic                            cfg_valid,
	input wire logic                            cfg_ready,
	input wire logic [bia_pkg::CFG_IDX_W-1:0]   cfg_index
);

	logic in_beat;
	logic range_wr;

	assign in_beat  = in_valid && !in_stall;
	assign range_wr = cfg_valid && cfg_ready &&
		(cfg_index == bia_pkg::REG_RANGE_LOW || cfg_index == bia_pkg::REG_RANGE_HIGH);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_idx_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != bia_pkg::ST_OK |-> out_data.result_index == 32'd0)
		else $error("result_index nonzero on failed request");

	a_set_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_set |->
			out_data.status == bia_pkg::ST_OK && out_data.result_index == 32'd0)
		else $error("is_set raised outside a successful query");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input taken while previous request in flight");

	a_clear_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		range_wr |=> in_stall && !in_beat)
		else $error("request taken during map clear");

endmodule

bind bitmap_index_allocator bia_chk u_bia_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);

`default_nettype wire
